[design/npf_pkg.sv]
// Shared constants and types for the next prime finder.
`default_nettype none

package npf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int VAL_W = DATA_WIDTH - 1;
    localparam int CNT_W = $clog2(VAL_W);
    localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] PRIME_FLOOR = VAL_W'(2);

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic [VAL_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[design/next_prime_finder.sv]
// Top level: finds the smallest prime at or above a signed start value.
// Each trial divisor costs one bit-serial division, started and checked by the control FSM.
// Negative starts and starts of two or less skip the divider; otherwise each tried candidate
// is divided by trial divisors from 2 up to its square root, until one divides it.
// One item is worked on at a time; a finished result waits in the output register.
// Reset is asynchronous and active low; it returns the block to idle with no result pending.
`default_nettype none

module next_prime_finder
    import npf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // start_value
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // next_prime, zero fill
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             start_reg;
    logic             start_next;
    logic [VAL_W-1:0] cand_reg;
    logic [VAL_W-1:0] cand_next;
    logic [VAL_W-1:0] dvs_reg;
    logic [VAL_W-1:0] dvs_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [VAL_W-1:0] out_data_reg;
    logic [VAL_W-1:0] out_data_next;
    logic             trivial;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign trivial = s_tdata[DATA_WIDTH-1] || (s_tdata[VAL_W-1:0] <= PRIME_FLOOR);

    assign div_req.start = start_reg;
    assign div_req.dividend = cand_reg;
    assign div_req.divisor = dvs_reg;

    npf_serial_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        cand_next = cand_reg;
        dvs_next = dvs_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (trivial)
                    begin
                        cand_next = PRIME_FLOOR;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cand_next = s_tdata[VAL_W-1:0];
                        dvs_next = PRIME_FLOOR;
                        start_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (dvs_reg > div_rsp.quotient)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (div_rsp.remainder == '0)
                    begin
                        cand_next = cand_reg + VAL_W'(1);
                        dvs_next = PRIME_FLOOR;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        dvs_next = dvs_reg + VAL_W'(1);
                        start_next = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = cand_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        dvs_reg <= dvs_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(OUT_TDATA_W - VAL_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

[design/npf_serial_div.sv]
// Bit-serial restoring divider that yields one quotient bit per cycle.
`default_nettype none

module npf_serial_div
    import npf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [VAL_W-1:0] dvd_reg;
    logic [VAL_W-1:0] dvd_next;
    logic [VAL_W-1:0] rem_reg;
    logic [VAL_W-1:0] rem_next;
    logic [VAL_W-1:0] dvs_reg;
    logic [VAL_W-1:0] dvs_next;
    logic [VAL_W:0]   shifted;
    logic [VAL_W:0]   trial;
    logic             last_step;

    assign shifted = {rem_reg, dvd_reg[VAL_W-1]};
    assign trial = shifted - {1'b0, dvs_reg};
    assign last_step = (count_reg == CNT_W'(VAL_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        count_next = count_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            count_next = '0;
            dvd_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[VAL_W])
            begin
                rem_next = trial[VAL_W-1:0];
                dvd_next = {dvd_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VAL_W-1:0];
                dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
            end
            count_next = count_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire
